@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is high
`define OPU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, also during reset
`define OPU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OPU_ASSERT(lbl, clk, rst, prop, msg)
`define OPU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/opu_pkg.sv @@
// ----------------------------------------------------------------------------
// opu_pkg
// Shared types, constants and the nibble reduction for the order unit.
// ----------------------------------------------------------------------------
`default_nettype none

package opu_pkg;

   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] NIB_MASK = 4'hF;
   localparam logic [IDX_W-1:0] ALGO_RESET = 4'd14;

   typedef struct packed {
      logic [IDX_W-1:0] lo_idx;
      logic [IDX_W-1:0] hi_idx;
      logic             last;
   } item_type;

   // nib mod n for a 4-bit nibble, n in 1..15; one candidate quotient per lane
   function automatic logic [IDX_W-1:0] nib_mod(input logic [IDX_W-1:0] nib,
                                                input logic [IDX_W-1:0] n);
      logic [7:0]       base;
      logic [7:0]       nib_w;
      logic [IDX_W-1:0] r;
      r     = '0;
      nib_w = {4'b0, nib};
      for (int q = 0; q < 16; q++) begin
         base = 8'(q) * {4'b0, n};
         if ((nib_w >= base) && (nib_w < (base + {4'b0, n}))) begin
            r = nib - base[IDX_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/opu_fifo.sv @@
// ----------------------------------------------------------------------------
// opu_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module opu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

@@ rtl/opu_front.sv @@
// ----------------------------------------------------------------------------
// opu_front
// Takes seed words, reduces both nibbles modulo the index count and queues
// the classified word for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module opu_front
   import opu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] n_eff,
   input  wire logic             req_push,
   input  wire logic [7:0]       req_seed_byte,
   input  wire logic             req_last_byte,
   output logic                  req_full,
   output item_type              item,
   output logic                  item_avail,
   input  wire logic             item_take
);

   item_type cls;
   logic     q_empty;

   always_comb begin
      cls.lo_idx = nib_mod(req_seed_byte[3:0] & NIB_MASK, n_eff);
      cls.hi_idx = nib_mod(req_seed_byte[7:4] & NIB_MASK, n_eff);
      cls.last   = req_last_byte;
   end

   opu_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (2)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (cls),
      .full  (req_full),
      .pop   (item_take),
      .dout  (item),
      .empty (q_empty)
   );

   assign item_avail = !q_empty;

endmodule

`default_nettype wire

@@ rtl/opu_back.sv @@
// ----------------------------------------------------------------------------
// opu_back
// Checks queued indices against the used mask, fills the unused ones on the
// last word and queues the resulting words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module opu_back
   import opu_pkg::*;
#(
   parameter int MAX_INDICES = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] n_eff,
   input  wire item_type         item,
   input  wire logic             item_avail,
   output logic                  item_take,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [IDX_W-1:0]      rsp_chosen_index,
   output logic [IDX_W-1:0]      rsp_order_position,
   output logic                  rsp_order_done
);

   localparam int MIW = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1;
   localparam int RW  = 2 * IDX_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_FILL
   } state_type;

   state_type              state_ff, state_in;
   item_type               cur_ff, cur_in;
   logic [IDX_W-1:0]       fill_i_ff, fill_i_in;
   logic [MAX_INDICES-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;

   logic             out_full;
   logic             step;
   logic [IDX_W-1:0] cand;
   logic             emit;
   logic             fill_end;
   logic [RW-1:0]    out_din, out_dout;

   always_comb begin
      unique case (state_ff)
         ST_LO:   cand = cur_ff.lo_idx;
         ST_HI:   cand = cur_ff.hi_idx;
         default: cand = fill_i_ff;
      endcase
   end

   assign step = (state_ff != ST_IDLE) && !out_full;
   assign emit = step && (cnt_ff < n_eff) && !mask_ff[cand[MIW-1:0]];
   assign out_din = {cand, cnt_ff, ({1'b0, cnt_ff} + 5'd1) == {1'b0, n_eff}};

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      fill_i_in = fill_i_ff;
      mask_in   = mask_ff;
      cnt_in    = cnt_ff;
      item_take = 1'b0;
      fill_end  = 1'b0;

      if (emit) begin
         mask_in[cand[MIW-1:0]] = 1'b1;
         cnt_in                 = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_avail) begin
               item_take = 1'b1;
               cur_in    = item;
               state_in  = ST_LO;
            end
         end
         ST_LO: begin
            if (step) begin
               state_in = ST_HI;
            end
         end
         ST_HI: begin
            if (step) begin
               if (cur_ff.last) begin
                  fill_i_in = '0;
                  state_in  = ST_FILL;
               end else if (item_avail) begin
                  item_take = 1'b1;
                  cur_in    = item;
                  state_in  = ST_LO;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            if (step) begin
               fill_i_in = fill_i_ff + 1'b1;
               fill_end  = (fill_i_ff == (n_eff - 4'd1)) || (cnt_in >= n_eff);
               if (fill_end) begin
                  mask_in  = '0;
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mask_ff   <= '0;
         cnt_ff    <= '0;
         fill_i_ff <= '0;
         cur_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         mask_ff   <= mask_in;
         cnt_ff    <= cnt_in;
         fill_i_ff <= fill_i_in;
         cur_ff    <= cur_in;
      end
   end

   opu_fifo #(
      .WIDTH (RW),
      .DEPTH (2)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (emit),
      .din   (out_din),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (out_dout),
      .empty (rsp_empty)
   );

   assign rsp_chosen_index   = out_dout[RW-1 -: IDX_W];
   assign rsp_order_position = out_dout[IDX_W:1];
   assign rsp_order_done     = out_dout[0];

   `OPU_ASSERT(a_emit_room, clock, reset, emit |-> !out_full, "word emitted into full queue")
   `OPU_ASSERT(a_emit_fresh, clock, reset, emit |-> !mask_ff[cand[MIW-1:0]], "index emitted twice")
   `OPU_ASSERT(a_fill_clears, clock, reset, fill_end |=> (cnt_ff == '0 && mask_ff == '0), "seed state not cleared")
   `OPU_ASSERT(a_take_slot, clock, reset, item_take |-> item_avail, "item taken from empty queue")

endmodule

`default_nettype wire

@@ rtl/nibble_driven_order_permutation_unit.sv @@
// ----------------------------------------------------------------------------
// nibble_driven_order_permutation_unit
// Builds a permutation of 0..n-1 from seed words, one nibble at a time.
//
//   channel  direction  handshake              payload
//   req      in         req_push / req_full    seed_byte, last_byte
//   rsp      out        rsp_pop / rsp_empty    chosen_index, order_position,
//                                              order_done
//   csr      in         csr_valid / csr_ready  algo_count
//
// The back end checks each seed word in two states, one per nibble check, plus
// a pass through idle to pick the word up when the back end was idle.
// A last word adds a fill walk over 0..n-1, cut short once n are out, then idle.
// A two-entry queue after the front and another before rsp decouple stalls.
// Reset is synchronous; mask and count clear at once, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_driven_order_permutation_unit
   import opu_pkg::*;
#(
   parameter int MAX_INDICES = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [7:0]       req_seed_byte,
   input  wire logic             req_last_byte,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [IDX_W-1:0]      rsp_chosen_index,
   output logic [IDX_W-1:0]      rsp_order_position,
   output logic                  rsp_order_done,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [IDX_W-1:0] csr_algo_count
);

   logic [IDX_W-1:0] algo_count_ff, algo_count_in;
   logic [IDX_W-1:0] n_eff;
   item_type         item;
   logic             item_avail;
   logic             item_take;

   assign csr_ready     = 1'b1;
   assign algo_count_in = (csr_valid && csr_ready) ? csr_algo_count : algo_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         algo_count_ff <= ALGO_RESET;
      end else begin
         algo_count_ff <= algo_count_in;
      end
   end

   // zero acts as one, limited to the index capacity
   always_comb begin
      n_eff = (algo_count_ff == '0) ? 4'd1 : algo_count_ff;
      if ({1'b0, n_eff} > 5'(MAX_INDICES)) begin
         n_eff = IDX_W'(MAX_INDICES);
      end
   end

   opu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .n_eff         (n_eff),
      .req_push      (req_push),
      .req_seed_byte (req_seed_byte),
      .req_last_byte (req_last_byte),
      .req_full      (req_full),
      .item          (item),
      .item_avail    (item_avail),
      .item_take     (item_take)
   );

   opu_back #(
      .MAX_INDICES (MAX_INDICES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .n_eff              (n_eff),
      .item               (item),
      .item_avail         (item_avail),
      .item_take          (item_take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_order_position (rsp_order_position),
      .rsp_order_done     (rsp_order_done)
   );

endmodule

`default_nettype wire
